@@ hw/rtl/dual_load_cell_adc_reader_defines.svh @@
// Assertion macros for the port-level checker of the dual load-cell reader.
// No dependencies. The user must have clk and arst_n in scope.
`ifndef DUAL_LOAD_CELL_ADC_READER_DEFINES_SVH
`define DUAL_LOAD_CELL_ADC_READER_DEFINES_SVH

// Clocked property that is disabled while reset is asserted.
`define DLCAR_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Implication from a condition to a property, checked every clock.
`define DLCAR_ASSERT_IMPL(label, cond, prop, msg) \
	`DLCAR_ASSERT(label, (cond) |-> (prop), msg)

`endif

@@ hw/rtl/dlcar_pkg.sv @@
// Package for the dual load-cell reader: operation codes, register indexes,
// word types. No dependencies.
package dlcar_pkg;

	localparam int VALUE_BITS = 24;

	typedef enum logic [1:0] {
		OP_TICK      = 2'd0,
		OP_START     = 2'd1,
		OP_PWR_UP    = 2'd2,
		OP_PWR_DOWN  = 2'd3
	} op_t;

	localparam logic [1:0] CFG_LEFT_EN    = 2'd0;
	localparam logic [1:0] CFG_RIGHT_EN   = 2'd1;
	localparam logic [1:0] CFG_LEFT_GAIN  = 2'd2;
	localparam logic [1:0] CFG_RIGHT_GAIN = 2'd3;

	localparam logic CELL_LEFT  = 1'b0;
	localparam logic CELL_RIGHT = 1'b1;

	typedef struct packed {
		op_t  op;
		logic cell_select;
		logic left_dout;
		logic right_dout;
	} item_t;

	typedef struct packed {
		logic                  left_sck;
		logic                  right_sck;
		logic                  busy;
		logic                  sample_valid;
		logic [VALUE_BITS-1:0] left_value;
		logic [VALUE_BITS-1:0] right_value;
		logic                  left_ready;
		logic                  right_ready;
	} result_t;

endpackage

@@ hw/rtl/dual_load_cell_adc_reader.sv @@
// Dual load-cell reader: reads two 24-bit bridge converters in lockstep over their
// clock/data links, one word per half clock period of the link. Every word is taken
// into an input register, processed combinationally by the sequencer and placed in a
// result register, so the block accepts one word per clock unless the result register
// is stalled. A word may enter while a finished result still waits to be taken.
// Configuration writes must be made by the user only while the block is idle; the
// block itself does not enforce this.
// Depends on dlcar_pkg, dlcar_in_stage and dlcar_core.
module dual_load_cell_adc_reader #(
	parameter int DATA_BITS = 24
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [1:0]  cfg_wdata,
	input  logic        item_valid,
	output logic        item_ready,
	input  logic [1:0]  operation,
	input  logic        cell_select,
	input  logic        left_dout,
	input  logic        right_dout,
	output logic        result_valid,
	input  logic        result_ready,
	output logic        left_sck,
	output logic        right_sck,
	output logic        busy_res,
	output logic        sample_valid,
	output logic [23:0] left_value,
	output logic [23:0] right_value,
	output logic        left_ready,
	output logic        right_ready
);

	dlcar_pkg::item_t   in_item;
	dlcar_pkg::item_t   item_s1;
	dlcar_pkg::result_t res_next;
	dlcar_pkg::result_t result_s2;
	logic               valid_s1;
	logic               valid_s2;
	logic               advance;

	assign in_item.op          = dlcar_pkg::op_t'(operation);
	assign in_item.cell_select = cell_select;
	assign in_item.left_dout   = left_dout;
	assign in_item.right_dout  = right_dout;

	// The word in the input register moves on when the result register is empty or being taken.
	assign advance = valid_s1 && (!valid_s2 || result_ready);

	dlcar_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (item_valid),
		.in_ready (item_ready),
		.in_item  (in_item),
		.take     (advance),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	dlcar_core #(
		.DATA_BITS (DATA_BITS)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.step      (advance),
		.item      (item_s1),
		.res       (res_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || result_ready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= res_next;
		end
	end

	assign result_valid = valid_s2;
	assign left_sck     = result_s2.left_sck;
	assign right_sck    = result_s2.right_sck;
	assign busy_res     = result_s2.busy;
	assign sample_valid = result_s2.sample_valid;
	assign left_value   = result_s2.left_value;
	assign right_value  = result_s2.right_value;
	assign left_ready   = result_s2.left_ready;
	assign right_ready  = result_s2.right_ready;

endmodule

@@ hw/rtl/dlcar_in_stage.sv @@
// Input register of the dual load-cell reader: holds one accepted word.
// Depends on dlcar_pkg.
module dlcar_in_stage (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  dlcar_pkg::item_t in_item,
	input  logic            take,
	output logic            valid_s1,
	output dlcar_pkg::item_t item_s1
);

	// A new word may enter when the stage is empty or is being drained this cycle.
	assign in_ready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_item;
		end
	end

endmodule

@@ hw/rtl/dlcar_core.sv @@
// Read sequencer of the dual load-cell reader: configuration, pulse counter,
// shift registers, clock levels and latched values. Depends on dlcar_pkg.
module dlcar_core #(
	parameter int DATA_BITS = 24
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_index,
	input  logic [1:0]        cfg_wdata,
	input  logic              step,
	input  dlcar_pkg::item_t  item,
	output dlcar_pkg::result_t res
);

	localparam int CW = $clog2(DATA_BITS + 4);
	localparam int VB = dlcar_pkg::VALUE_BITS;
	localparam logic [CW-1:0] DB_C = CW'(DATA_BITS);

	logic                 left_en_q, right_en_q;
	logic [1:0]           left_gain_q, right_gain_q;
	logic [CW-1:0]        pulse_count_q, pulse_count_d;
	logic                 high_phase_q, high_phase_d;
	logic                 active_q, active_d;
	logic [DATA_BITS-1:0] left_shift_q, left_shift_d;
	logic [DATA_BITS-1:0] right_shift_q, right_shift_d;
	logic                 left_clk_q, left_clk_d;
	logic                 right_clk_q, right_clk_d;
	logic [VB-1:0]        left_held_q, left_held_d;
	logic [VB-1:0]        right_held_q, right_held_d;
	logic                 valid_d;

	logic                 in_data;
	logic [CW-1:0]        extra_count;
	logic                 left_pulsed, right_pulsed;
	logic [1:0]           max_gain;
	logic [CW-1:0]        total;
	logic [CW-1:0]        count_inc;
	logic [DATA_BITS+VB-1:0] left_ext, right_ext;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_en_q    <= 1'b1;
			right_en_q   <= 1'b1;
			left_gain_q  <= 2'd1;
			right_gain_q <= 2'd1;
		end else if (cfg_we) begin
			case (cfg_index)
				dlcar_pkg::CFG_LEFT_EN:    left_en_q    <= cfg_wdata[0];
				dlcar_pkg::CFG_RIGHT_EN:   right_en_q   <= cfg_wdata[0];
				dlcar_pkg::CFG_LEFT_GAIN:  left_gain_q  <= cfg_wdata;
				dlcar_pkg::CFG_RIGHT_GAIN: right_gain_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// A cell is pulsed during the data bits and then until its own gain count is reached.
	assign in_data      = pulse_count_q < DB_C;
	assign extra_count  = pulse_count_q - DB_C;
	assign left_pulsed  = left_en_q && (in_data || extra_count < CW'(left_gain_q));
	assign right_pulsed = right_en_q && (in_data || extra_count < CW'(right_gain_q));
	assign max_gain     = (left_gain_q > right_gain_q) ? left_gain_q : right_gain_q;
	assign total        = DB_C + CW'(max_gain);
	assign count_inc    = pulse_count_q + CW'(1);

	always_comb begin
		pulse_count_d = pulse_count_q;
		high_phase_d  = high_phase_q;
		active_d      = active_q;
		left_shift_d  = left_shift_q;
		right_shift_d = right_shift_q;
		left_clk_d    = left_clk_q;
		right_clk_d   = right_clk_q;
		left_held_d   = left_held_q;
		right_held_d  = right_held_q;
		valid_d       = 1'b0;
		left_ext      = {{VB{1'b0}}, left_shift_q};
		right_ext     = {{VB{1'b0}}, right_shift_q};
		case (item.op)
			dlcar_pkg::OP_TICK: begin
				if (active_q && !high_phase_q) begin
					if (left_pulsed) left_clk_d = 1'b1;
					if (right_pulsed) right_clk_d = 1'b1;
					high_phase_d = 1'b1;
				end else if (active_q) begin
					if (in_data) begin
						left_shift_d  = {left_shift_q[DATA_BITS-2:0], left_en_q & item.left_dout};
						right_shift_d = {right_shift_q[DATA_BITS-2:0],
							right_en_q & item.right_dout};
					end
					if (left_pulsed) left_clk_d = 1'b0;
					if (right_pulsed) right_clk_d = 1'b0;
					high_phase_d  = 1'b0;
					pulse_count_d = count_inc;
					if (count_inc >= total) begin
						active_d      = 1'b0;
						pulse_count_d = '0;
						left_ext      = {{VB{1'b0}}, left_shift_d};
						right_ext     = {{VB{1'b0}}, right_shift_d};
						left_held_d   = left_ext[VB-1:0];
						right_held_d  = right_ext[VB-1:0];
						valid_d       = 1'b1;
					end
				end
			end
			dlcar_pkg::OP_START: begin
				if (!active_q) begin
					if (left_en_q) left_clk_d = 1'b0;
					if (right_en_q) right_clk_d = 1'b0;
					left_shift_d  = '0;
					right_shift_d = '0;
					pulse_count_d = '0;
					high_phase_d  = 1'b0;
					active_d      = 1'b1;
				end
			end
			dlcar_pkg::OP_PWR_UP, dlcar_pkg::OP_PWR_DOWN: begin
				// Power-down holds the clock high; power-up releases it low.
				if (!active_q) begin
					if (item.cell_select == dlcar_pkg::CELL_RIGHT) begin
						right_clk_d = (item.op == dlcar_pkg::OP_PWR_DOWN);
					end else begin
						left_clk_d = (item.op == dlcar_pkg::OP_PWR_DOWN);
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pulse_count_q <= '0;
			high_phase_q  <= 1'b0;
			active_q      <= 1'b0;
			left_shift_q  <= '0;
			right_shift_q <= '0;
			left_clk_q    <= 1'b0;
			right_clk_q   <= 1'b0;
			left_held_q   <= '0;
			right_held_q  <= '0;
		end else if (step) begin
			pulse_count_q <= pulse_count_d;
			high_phase_q  <= high_phase_d;
			active_q      <= active_d;
			left_shift_q  <= left_shift_d;
			right_shift_q <= right_shift_d;
			left_clk_q    <= left_clk_d;
			right_clk_q   <= right_clk_d;
			left_held_q   <= left_held_d;
			right_held_q  <= right_held_d;
		end
	end

	always_comb begin
		res.left_sck     = left_clk_d;
		res.right_sck    = right_clk_d;
		res.busy         = active_d;
		res.sample_valid = valid_d;
		res.left_value   = left_held_d;
		res.right_value  = right_held_d;
		res.left_ready   = !item.left_dout;
		res.right_ready  = !item.right_dout;
	end

endmodule

@@ hw/rtl/dlcar_checker.sv @@
// Port-level checker for the dual load-cell reader, bound to the top level.
// Depends on dual_load_cell_adc_reader_defines.svh.
`include "dual_load_cell_adc_reader_defines.svh"

module dlcar_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        item_valid,
	input logic        item_ready,
	input logic        result_valid,
	input logic        result_ready,
	input logic        busy_res,
	input logic        sample_valid,
	input logic [23:0] left_value,
	input logic [23:0] right_value
);

	// A stalled result word keeps its values.
	`DLCAR_ASSERT(a_stall_hold, result_valid && !result_ready |=> result_valid && $stable(left_value) && $stable(right_value) && $stable(sample_valid), "result word changed while stalled")

	// A completed read always ends the sequence.
	`DLCAR_ASSERT_IMPL(a_done_not_busy, result_valid && sample_valid, !busy_res, "sample reported while still busy")

	// With no result waiting, the input side must be open.
	`DLCAR_ASSERT_IMPL(a_ready_when_drained, !result_valid, item_ready, "input blocked with empty result register")

	// While a result is stalled, at most one more word may be taken before the input closes.
	`DLCAR_ASSERT(a_bounded_fill, result_valid && !result_ready && item_valid && item_ready ##1 result_valid && !result_ready |-> !item_ready, "more words taken than the pipeline can hold")

endmodule

bind dual_load_cell_adc_reader dlcar_checker u_dlcar_checker (.*);

@@ dv/dual_load_cell_adc_reader_checker.sv @@
// Checker for the dual load-cell reader: tracks configuration writes, predicts every
// result word from the accepted input words and compares them in order.
// Depends on dlcar_pkg.
`timescale 1ns / 100ps

module dual_load_cell_adc_reader_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [1:0]  cfg_wdata,
	input  logic        item_valid,
	input  logic        item_ready,
	input  logic [1:0]  operation,
	input  logic        cell_select,
	input  logic        left_dout,
	input  logic        right_dout,
	input  logic        result_valid,
	input  logic        result_ready,
	input  logic        left_sck,
	input  logic        right_sck,
	input  logic        busy_res,
	input  logic        sample_valid,
	input  logic [23:0] left_value,
	input  logic [23:0] right_value,
	input  logic        left_ready,
	input  logic        right_ready,
	output int          errors,
	output int          pending,
	output int          checked,
	output int          conversions,
	output logic        reading
);

	localparam int DATA_BITS = dlcar_pkg::VALUE_BITS;
	localparam int SHOWN = 10;

	logic                 left_on, right_on;
	logic [1:0]           left_extra, right_extra;
	logic [4:0]           pulse_cnt;
	logic                 high_half;
	logic                 active;
	logic [DATA_BITS-1:0] left_acc, right_acc;
	logic                 left_clk, right_clk;
	logic [23:0]          left_held, right_held;
	dlcar_pkg::result_t   expected_q[$];

	// Advances the reader state by one input word and returns the word it should emit.
	task automatic predict_word(input dlcar_pkg::item_t w, output dlcar_pkg::result_t r);
		int   longest;
		logic lp, rp;
		longest = (left_extra > right_extra) ? int'(left_extra) : int'(right_extra);
		lp = left_on && (pulse_cnt < DATA_BITS || int'(pulse_cnt) - DATA_BITS < int'(left_extra));
		rp = right_on &&
			(pulse_cnt < DATA_BITS || int'(pulse_cnt) - DATA_BITS < int'(right_extra));
		r = '0;
		case (w.op)
			dlcar_pkg::OP_TICK: begin
				if (active && !high_half) begin
					if (lp) left_clk = 1'b1;
					if (rp) right_clk = 1'b1;
					high_half = 1'b1;
				end else if (active) begin
					// Data is shifted only during the data pulses, never during gain pulses.
					if (pulse_cnt < DATA_BITS) begin
						left_acc = {left_acc[DATA_BITS-2:0], left_on & w.left_dout};
						right_acc = {right_acc[DATA_BITS-2:0], right_on & w.right_dout};
					end
					if (lp) left_clk = 1'b0;
					if (rp) right_clk = 1'b0;
					high_half = 1'b0;
					pulse_cnt = pulse_cnt + 5'd1;
					if (int'(pulse_cnt) >= DATA_BITS + longest) begin
						active = 1'b0;
						pulse_cnt = '0;
						left_held = left_acc[23:0];
						right_held = right_acc[23:0];
						r.sample_valid = 1'b1;
					end
				end
			end
			dlcar_pkg::OP_START: begin
				if (!active) begin
					if (left_on) left_clk = 1'b0;
					if (right_on) right_clk = 1'b0;
					left_acc = '0;
					right_acc = '0;
					pulse_cnt = '0;
					high_half = 1'b0;
					active = 1'b1;
				end
			end
			default: begin
				if (!active) begin
					if (w.cell_select == dlcar_pkg::CELL_RIGHT)
						right_clk = (w.op == dlcar_pkg::OP_PWR_DOWN);
					else
						left_clk = (w.op == dlcar_pkg::OP_PWR_DOWN);
				end
			end
		endcase
		r.left_sck = left_clk;
		r.right_sck = right_clk;
		r.busy = active;
		r.left_value = left_held;
		r.right_value = right_held;
		r.left_ready = !w.left_dout;
		r.right_ready = !w.right_dout;
	endtask

	always @(posedge clk or negedge arst_n) begin
		dlcar_pkg::result_t want, got;
		if (!arst_n) begin
			left_on = 1'b1;
			right_on = 1'b1;
			left_extra = 2'd1;
			right_extra = 2'd1;
			pulse_cnt = '0;
			high_half = 1'b0;
			active = 1'b0;
			left_acc = '0;
			right_acc = '0;
			left_clk = 1'b0;
			right_clk = 1'b0;
			left_held = '0;
			right_held = '0;
			expected_q.delete();
			errors = 0;
			pending = 0;
			checked = 0;
			conversions = 0;
			reading = 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					dlcar_pkg::CFG_LEFT_EN:    left_on = cfg_wdata[0];
					dlcar_pkg::CFG_RIGHT_EN:   right_on = cfg_wdata[0];
					dlcar_pkg::CFG_LEFT_GAIN:  left_extra = cfg_wdata;
					dlcar_pkg::CFG_RIGHT_GAIN: right_extra = cfg_wdata;
					default: ;
				endcase
			end
			if (result_valid && result_ready) begin
				got = dlcar_pkg::result_t'({left_sck, right_sck, busy_res, sample_valid,
					left_value, right_value, left_ready, right_ready});
				if (expected_q.size() == 0) begin
					if (errors < SHOWN)
						$display("checker: result word arrived with nothing expected");
					errors++;
				end else begin
					want = expected_q.pop_front();
					if (got != want) begin
						if (errors < SHOWN)
							$display({"checker: result %0d: got sck %b%b busy %b valid %b ",
								"values %h %h ready %b%b, expected sck %b%b busy %b ",
								"valid %b values %h %h ready %b%b"}, checked,
								got.left_sck, got.right_sck, got.busy, got.sample_valid,
								got.left_value, got.right_value, got.left_ready,
								got.right_ready, want.left_sck, want.right_sck, want.busy,
								want.sample_valid, want.left_value, want.right_value,
								want.left_ready, want.right_ready);
						errors++;
					end
					checked++;
				end
			end
			if (item_valid && item_ready) begin
				predict_word(dlcar_pkg::item_t'({operation, cell_select, left_dout,
					right_dout}), want);
				if (want.sample_valid) conversions++;
				expected_q.push_back(want);
			end
			pending = expected_q.size();
			reading = active;
		end
	end

endmodule

@@ dv/dual_load_cell_adc_reader_tb.sv @@
// Testbench top for the dual load-cell reader: clock, reset, stimulus, configuration
// phases and the verdict. Depends on dlcar_pkg and dual_load_cell_adc_reader_checker.
`timescale 1ns / 100ps

module dual_load_cell_adc_reader_tb;

	localparam int STALL_LIMIT = 1000;
	localparam int PHASE_WORDS = 120;
	localparam int PHASES = 10;

	logic            clk = 1'b0;
	logic            arst_n;
	logic            cfg_we;
	logic [1:0]      cfg_index;
	logic [1:0]      cfg_wdata;
	logic            item_valid;
	logic            item_ready;
	dlcar_pkg::op_t  operation;
	logic            cell_select;
	logic            left_dout;
	logic            right_dout;
	logic            result_valid;
	logic            result_ready;
	logic            left_sck, right_sck;
	logic            busy_res;
	logic            sample_valid;
	logic [23:0]     left_value, right_value;
	logic            left_ready, right_ready;

	int   errors, pending, checked, conversions;
	logic reading;
	int   words_sent;
	int   settings_used;
	int   stall_cycles;
	bit   quiet;

	dual_load_cell_adc_reader u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.operation    (operation),
		.cell_select  (cell_select),
		.left_dout    (left_dout),
		.right_dout   (right_dout),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.left_sck     (left_sck),
		.right_sck    (right_sck),
		.busy_res     (busy_res),
		.sample_valid (sample_valid),
		.left_value   (left_value),
		.right_value  (right_value),
		.left_ready   (left_ready),
		.right_ready  (right_ready)
	);

	dual_load_cell_adc_reader_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.operation    (operation),
		.cell_select  (cell_select),
		.left_dout    (left_dout),
		.right_dout   (right_dout),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.left_sck     (left_sck),
		.right_sck    (right_sck),
		.busy_res     (busy_res),
		.sample_valid (sample_valid),
		.left_value   (left_value),
		.right_value  (right_value),
		.left_ready   (left_ready),
		.right_ready  (right_ready),
		.errors       (errors),
		.pending      (pending),
		.checked      (checked),
		.conversions  (conversions),
		.reading      (reading)
	);

	always #2 clk = ~clk;

	// Called at a falling edge; returns at the falling edge after the word is taken.
	// Valid stays high on return so back-to-back words need no second assignment.
	task automatic send_word(input dlcar_pkg::op_t op, input logic sel, input logic ld,
			input logic rd);
		int gap;
		gap = quiet ? 0 : $urandom_range(0, 13);
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		operation <= op;
		cell_select <= sel;
		left_dout <= ld;
		right_dout <= rd;
		item_valid <= 1'b1;
		@(posedge clk);
		while (!item_ready) @(posedge clk);
		@(negedge clk);
		words_sent++;
	endtask

	task automatic drain_results();
		item_valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
	endtask

	// Runs any read in progress to its end with random data on the lines.
	task automatic finish_read();
		while (reading)
			send_word(dlcar_pkg::OP_TICK, 1'($urandom_range(0, 1)),
				1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
	endtask

	// One read: the falling-half ticks carry the given bits, MSB first. With meddle set,
	// commands that a busy reader must ignore are mixed into the sequence.
	task automatic read_conversion(input logic [23:0] lbits, input logic [23:0] rbits,
			input bit meddle);
		int   k;
		logic ld, rd;
		send_word(dlcar_pkg::OP_START, 1'($urandom_range(0, 1)),
			1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
		k = 0;
		while (reading) begin
			if (meddle && $urandom_range(0, 11) == 0) begin
				send_word(dlcar_pkg::op_t'($urandom_range(1, 3)), 1'($urandom_range(0, 1)),
					1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
			end else begin
				ld = 1'($urandom_range(0, 1));
				rd = 1'($urandom_range(0, 1));
				if (k % 2 == 1 && k / 2 < dlcar_pkg::VALUE_BITS) begin
					ld = lbits[dlcar_pkg::VALUE_BITS - 1 - k / 2];
					rd = rbits[dlcar_pkg::VALUE_BITS - 1 - k / 2];
				end
				send_word(dlcar_pkg::OP_TICK, 1'($urandom_range(0, 1)), ld, rd);
				k++;
			end
		end
	endtask

	task automatic noise_burst();
		int n;
		n = $urandom_range(1, 6);
		repeat (n)
			send_word(dlcar_pkg::op_t'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
				1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
	endtask

	// Settings change only with the reader idle and every result word taken.
	task automatic apply_setting(input logic le, input logic re, input logic [1:0] lg,
			input logic [1:0] rg);
		finish_read();
		drain_results();
		repeat (4) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= dlcar_pkg::CFG_LEFT_EN;
		cfg_wdata <= {1'b0, le};
		@(negedge clk);
		cfg_index <= dlcar_pkg::CFG_RIGHT_EN;
		cfg_wdata <= {1'b0, re};
		@(negedge clk);
		cfg_index <= dlcar_pkg::CFG_LEFT_GAIN;
		cfg_wdata <= lg;
		@(negedge clk);
		cfg_index <= dlcar_pkg::CFG_RIGHT_GAIN;
		cfg_wdata <= rg;
		@(negedge clk);
		cfg_we <= 1'b0;
		settings_used++;
	endtask

	always @(posedge clk) begin
		if (!arst_n || (item_valid && item_ready) || (result_valid && result_ready) || cfg_we) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("tb: failure");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	initial begin : take_results
		int hold;
		result_ready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			hold = quiet ? 0 : $urandom_range(0, 13);
			if (hold > 0) begin
				result_ready <= 1'b0;
				repeat (hold) @(negedge clk);
			end
			result_ready <= 1'b1;
			do @(posedge clk); while (!result_valid);
			@(negedge clk);
		end
	end

	initial begin : stimulus
		int          base;
		int          pick;
		logic [23:0] lbits, rbits;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = dlcar_pkg::CFG_LEFT_EN;
		cfg_wdata = '0;
		item_valid = 1'b0;
		operation = dlcar_pkg::OP_TICK;
		cell_select = dlcar_pkg::CELL_LEFT;
		left_dout = 1'b0;
		right_dout = 1'b0;
		quiet = 1'b0;
		words_sent = 0;
		settings_used = 1;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Idle tick, power commands on both cells, then a start over a powered-down line.
		send_word(dlcar_pkg::OP_TICK, dlcar_pkg::CELL_LEFT, 1'b1, 1'b0);
		send_word(dlcar_pkg::OP_PWR_DOWN, dlcar_pkg::CELL_LEFT, 1'b1, 1'b1);
		send_word(dlcar_pkg::OP_PWR_DOWN, dlcar_pkg::CELL_RIGHT, 1'b0, 1'b1);
		send_word(dlcar_pkg::OP_PWR_UP, dlcar_pkg::CELL_LEFT, 1'b0, 1'b0);
		send_word(dlcar_pkg::OP_PWR_UP, dlcar_pkg::CELL_RIGHT, 1'b1, 1'b0);
		send_word(dlcar_pkg::OP_PWR_DOWN, dlcar_pkg::CELL_RIGHT, 1'b0, 1'b0);
		send_word(dlcar_pkg::OP_START, dlcar_pkg::CELL_LEFT, 1'b0, 1'b0);
		// A second start and power commands while busy must all be ignored.
		send_word(dlcar_pkg::OP_TICK, dlcar_pkg::CELL_LEFT, 1'b1, 1'b1);
		send_word(dlcar_pkg::OP_START, dlcar_pkg::CELL_RIGHT, 1'b1, 1'b1);
		send_word(dlcar_pkg::OP_PWR_DOWN, dlcar_pkg::CELL_LEFT, 1'b0, 1'b1);
		send_word(dlcar_pkg::OP_PWR_UP, dlcar_pkg::CELL_RIGHT, 1'b1, 1'b0);
		finish_read();
		read_conversion(24'hFFFFFF, 24'h000000, 1'b0);
		read_conversion(24'h800000, 24'h7FFFFF, 1'b0);
		read_conversion(24'h000000, 24'hFFFFFF, 1'b0);

		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: ;
				1: apply_setting(1'b1, 1'b1, 2'd3, 2'd3);
				2: apply_setting(1'b1, 1'b0, 2'd1, 2'd3);
				3: apply_setting(1'b0, 1'b1, 2'd2, 2'd0);
				4: apply_setting(1'b0, 1'b0, 2'd3, 2'd1);
				5: apply_setting(1'b1, 1'b1, 2'd0, 2'd0);
				6: apply_setting(1'b1, 1'b1, 2'd2, 2'd1);
				default: apply_setting(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
					2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)));
			endcase
			base = words_sent;
			while (words_sent - base < PHASE_WORDS) begin
				quiet = ($urandom_range(0, 3) == 0);
				pick = $urandom_range(0, 19);
				if (pick < 15) begin
					lbits = 24'($urandom);
					rbits = 24'($urandom);
					if (pick == 0) lbits = 24'h800000;
					if (pick == 1) rbits = 24'h7FFFFF;
					read_conversion(lbits, rbits, $urandom_range(0, 3) == 0);
				end else if (pick < 19) begin
					noise_burst();
				end else begin
					drain_results();
				end
			end
		end

		quiet = 1'b0;
		drain_results();
		repeat (8) @(posedge clk);
		@(negedge clk);
		$display("run: %0d words sent under %0d register settings, %0d result words checked",
			words_sent, settings_used, checked);
		$display("run: %0d completed conversions, %0d mismatches", conversions, errors);
		if (errors == 0 && pending == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

@@ sim.f @@
+incdir+hw/rtl
hw/rtl/dlcar_pkg.sv
hw/rtl/dlcar_in_stage.sv
hw/rtl/dlcar_core.sv
hw/rtl/dual_load_cell_adc_reader.sv
hw/rtl/dlcar_checker.sv
dv/dual_load_cell_adc_reader_checker.sv
dv/dual_load_cell_adc_reader_tb.sv
